@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the tick front end and the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned ActionWidth = 3;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned BitCntWidth = 4;

  // Register reset values.
  localparam logic [CfgWidth-1:0] HalfPeriodReset = 16'd5;
  localparam logic [CfgWidth-1:0] StretchReset    = 16'd1000;

  // Bit counter landmarks: last data bit and the acknowledge bit.
  localparam logic [BitCntWidth-1:0] LastDataBit = 4'd7;
  localparam logic [BitCntWidth-1:0] DataBits    = 4'd8;

  // Action codes on the input channel.
  typedef enum logic [ActionWidth-1:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4
  } action_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_HALF_PERIOD = 1'b0,
    REG_STRETCH     = 1'b1
  } cfg_reg_e;

  // Status codes.
  typedef enum logic [StatusWidth-1:0] {
    ST_OK      = 2'd0,
    ST_NACK    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  // Classified command kind; unknown action codes fold into no command.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_e;

  // One classified tick as it travels through the queue.
  typedef struct packed {
    cmd_kind_e            kind;
    logic [ByteWidth-1:0] data;
    logic                 ack;
    logic                 scl;
    logic                 sda;
  } tick_item_t;

  // Level to put on SDA for the bit about to be driven.
  function automatic logic bit_level(input logic [BitCntWidth-1:0] bit_cnt,
                                     input logic                   rd_mode,
                                     input logic [ByteWidth-1:0]   shift,
                                     input logic                   send_ack);
    logic lvl;
    if (bit_cnt < DataBits) begin
      lvl = rd_mode ? 1'b1 : shift[ByteWidth-1];
    end else begin
      lvl = rd_mode ? ~send_ack : 1'b1;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

@@ rtl/i2c_master_byte_engine_unit.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C master driven by byte commands, one timebase tick per item.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  in        in_valid_i/in_ready_o   action, cmd_byte, ack_after_read, scl_in, sda_in
//  out       out_valid_o/out_ready_i scl/sda_release, busy_res, done_res, read_data, status
//  cfg       cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
//  One tick is taken every clock cycle while the tick queue has room; each tick gives
//  its result item in the cycle after it leaves the two-entry tick queue.
//  The sequencer steps once per tick, set by the single result register.
//  Reset is asynchronous and active low; it releases both lines and restores
//  the register defaults. A stalled output holds the sequencer while the queue
//  keeps taking up to two further ticks.
`default_nettype none

module i2c_master_byte_engine_unit #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_idx_i,
  input  wire  [i2cm_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [i2cm_pkg::ActionWidth-1:0] action_i,
  input  wire  [i2cm_pkg::ByteWidth-1:0]   cmd_byte_i,
  input  wire                              ack_after_read_i,
  input  wire                              scl_in_i,
  input  wire                              sda_in_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             scl_release_o,
  output logic                             sda_release_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic [i2cm_pkg::ByteWidth-1:0]   read_data_o,
  output logic [i2cm_pkg::StatusWidth-1:0] status_o
);
  import i2cm_pkg::*;

  logic       q_valid;
  logic       q_pop;
  tick_item_t q_item;

  // Front end: classify ticks and queue them.
  i2cm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .cmd_byte_i       (cmd_byte_i),
    .ack_after_read_i (ack_after_read_i),
    .scl_in_i         (scl_in_i),
    .sda_in_i         (sda_in_i),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  // Back end: bit sequencer and result register.
  i2cm_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_release_o (scl_release_o),
    .sda_release_o (sda_release_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .read_data_o   (read_data_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

@@ rtl/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// I2C master tick front end
// Accepts ticks, classifies the action code and holds them in a two-entry
// queue in front of the bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [i2cm_pkg::ActionWidth-1:0] action_i,
  input  wire  [i2cm_pkg::ByteWidth-1:0]   cmd_byte_i,
  input  wire                           ack_after_read_i,
  input  wire                           scl_in_i,
  input  wire                           sda_in_i,
  output logic                          q_valid_o,
  output i2cm_pkg::tick_item_t          q_item_o,
  input  wire                           q_pop_i
);
  import i2cm_pkg::*;

  tick_item_t  item_in;
  tick_item_t  slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;

  // Classify the action; reserved codes become no command.
  always_comb begin
    case (action_e'(action_i))
      ACT_START: item_in.kind = CMD_START;
      ACT_STOP:  item_in.kind = CMD_STOP;
      ACT_WRITE: item_in.kind = CMD_WRITE;
      ACT_READ:  item_in.kind = CMD_READ;
      default:   item_in.kind = CMD_NONE;
    endcase
    item_in.data = cmd_byte_i;
    item_in.ack  = ack_after_read_i;
    item_in.scl  = scl_in_i;
    item_in.sda  = sda_in_i;
  end

  // Queue handshake.
  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  // The fill count never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("tick queue overfilled");

endmodule

`default_nettype wire

@@ rtl/i2cm_engine.sv @@
// ----------------------------------------------------------------------------
// I2C master bit engine
// Runs start, stop and byte sequences one tick at a time, honours clock
// stretching and presents the line drives and status as a registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_engine #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_idx_i,
  input  wire  [i2cm_pkg::CfgWidth-1:0]    cfg_wdata_i,
  input  wire                              q_valid_i,
  input  wire  i2cm_pkg::tick_item_t       q_item_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             scl_release_o,
  output logic                             sda_release_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic [i2cm_pkg::ByteWidth-1:0]   read_data_o,
  output logic [i2cm_pkg::StatusWidth-1:0] status_o
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_WAIT,
    PH_ST_HIGH,
    PH_ST_SDA,
    PH_ST_SCL,
    PH_SP_WAIT,
    PH_SP_HIGH,
    PH_SP_SDA,
    PH_BIT_LOW,
    PH_BIT_WAIT,
    PH_BIT_HIGH,
    PH_TAIL
  } phase_e;

  logic [CfgWidth-1:0]    half_q, stretch_q;
  logic [TIMER_WIDTH-1:0] half_clip, stretch_lim, hold_lim;
  logic [TIMER_WIDTH-1:0] tick_inc, str_inc;
  logic                   hold_over, str_timeout;

  phase_e                 phase_q, phase_d;
  logic [BitCntWidth-1:0] bc_q, bc_d;
  logic [ByteWidth-1:0]   sr_q, sr_d, shift_new;
  logic [TIMER_WIDTH-1:0] tick_q, tick_d;
  logic [TIMER_WIDTH-1:0] str_q, str_d;
  logic                   ack_q, ack_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic [StatusWidth-1:0] st_q, st_d;
  logic                   rd_q, rd_d;
  logic                   nack_q, nack_d;
  logic [ByteWidth-1:0]   rx_q, rx_d;
  logic                   done_q, done_d;
  logic                   out_valid_q;
  logic                   step;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= HalfPeriodReset;
      stretch_q <= StretchReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HALF_PERIOD: half_q    <= cfg_wdata_i;
        REG_STRETCH:     stretch_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Register values clipped to what the timers can count.
  if (TIMER_WIDTH >= CfgWidth) begin : g_wide_timer
    assign half_clip   = TIMER_WIDTH'(half_q);
    assign stretch_lim = TIMER_WIDTH'(stretch_q);
  end else begin : g_narrow_timer
    assign half_clip   = (|half_q[CfgWidth-1:TIMER_WIDTH]) ? '1 : half_q[TIMER_WIDTH-1:0];
    assign stretch_lim = (|stretch_q[CfgWidth-1:TIMER_WIDTH]) ? '1 :
                         stretch_q[TIMER_WIDTH-1:0];
  end

  // Saturating tick and stretch counters with their limit compares.
  always_comb begin
    hold_lim    = (half_clip == '0) ? TIMER_WIDTH'(1) : half_clip;
    tick_inc    = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
    str_inc     = (str_q != '1) ? str_q + 1'b1 : str_q;
    hold_over   = (tick_inc >= hold_lim);
    str_timeout = (str_inc >= stretch_lim);
  end

  // One tick is executed whenever the result slot is free or being emptied.
  assign step    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = step;

  // Sequencer next state for one tick.
  always_comb begin
    phase_d   = phase_q;
    bc_d      = bc_q;
    sr_d      = sr_q;
    tick_d    = tick_q;
    str_d     = str_q;
    ack_d     = ack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    st_d      = st_q;
    rd_d      = rd_q;
    nack_d    = nack_q;
    rx_d      = rx_q;
    done_d    = 1'b0;
    shift_new = {sr_q[ByteWidth-2:0], q_item_i.sda};

    case (phase_q)
      PH_IDLE: begin
        tick_d = '0;
        str_d  = '0;
        case (q_item_i.kind)
          CMD_START: begin
            phase_d = PH_ST_WAIT;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          CMD_STOP: begin
            phase_d = PH_SP_WAIT;
            scl_d   = 1'b1;
            sda_d   = 1'b0;
          end
          CMD_WRITE, CMD_READ: begin
            rd_d    = (q_item_i.kind == CMD_READ);
            ack_d   = q_item_i.ack;
            sr_d    = rd_d ? '0 : q_item_i.data;
            bc_d    = '0;
            nack_d  = 1'b0;
            phase_d = PH_BIT_LOW;
            scl_d   = 1'b0;
            sda_d   = bit_level('0, rd_d, sr_d, ack_d);
          end
          default: begin
            tick_d = tick_q;
            str_d  = str_q;
          end
        endcase
      end

      // Waiting for a released SCL to read high.
      PH_ST_WAIT, PH_SP_WAIT, PH_BIT_WAIT: begin
        if (q_item_i.scl) begin
          tick_d = '0;
          str_d  = '0;
          scl_d  = 1'b1;
          case (phase_q)
            PH_ST_WAIT: begin
              phase_d = PH_ST_HIGH;
              sda_d   = 1'b1;
            end
            PH_SP_WAIT: begin
              phase_d = PH_SP_HIGH;
              sda_d   = 1'b0;
            end
            default: phase_d = PH_BIT_HIGH;
          endcase
        end else begin
          str_d = str_inc;
          if (str_timeout) begin
            if (phase_q == PH_BIT_WAIT && rd_q && bc_q < DataBits) begin
              rx_d = '0;
            end
            phase_d = PH_IDLE;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            tick_d  = '0;
            str_d   = '0;
            st_d    = ST_TIMEOUT;
            done_d  = 1'b1;
          end
        end
      end

      // Timed half periods.
      PH_ST_HIGH, PH_ST_SDA, PH_ST_SCL, PH_SP_HIGH, PH_SP_SDA,
      PH_BIT_LOW, PH_BIT_HIGH, PH_TAIL: begin
        tick_d = tick_inc;
        if (hold_over) begin
          tick_d = '0;
          str_d  = '0;
          case (phase_q)
            PH_ST_HIGH: begin
              phase_d = PH_ST_SDA;
              scl_d   = 1'b1;
              sda_d   = 1'b0;
            end
            PH_ST_SDA: begin
              phase_d = PH_ST_SCL;
              scl_d   = 1'b0;
              sda_d   = 1'b0;
            end
            PH_ST_SCL: begin
              phase_d = PH_IDLE;
              scl_d   = 1'b0;
              sda_d   = 1'b0;
              st_d    = ST_OK;
              done_d  = 1'b1;
            end
            PH_SP_HIGH: begin
              phase_d = PH_SP_SDA;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
            end
            PH_SP_SDA: begin
              phase_d = PH_IDLE;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
              st_d    = ST_OK;
              done_d  = 1'b1;
            end
            PH_BIT_LOW: begin
              phase_d = PH_BIT_WAIT;
              scl_d   = 1'b1;
            end
            PH_BIT_HIGH: begin
              if (bc_q < DataBits) begin
                // Sample SDA at the end of the high half and move on.
                sr_d = shift_new;
                if (bc_q == LastDataBit && rd_q) begin
                  rx_d = shift_new;
                end
                bc_d    = bc_q + 1'b1;
                phase_d = PH_BIT_LOW;
                scl_d   = 1'b0;
                sda_d   = bit_level(bc_d, rd_q, shift_new, ack_q);
              end else begin
                nack_d  = rd_q ? 1'b0 : q_item_i.sda;
                phase_d = PH_TAIL;
                scl_d   = 1'b0;
              end
            end
            default: begin
              phase_d = PH_IDLE;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              st_d    = nack_q ? ST_NACK : ST_OK;
              done_d  = 1'b1;
            end
          endcase
        end
      end

      default: begin
        phase_d = PH_IDLE;
        scl_d   = 1'b1;
        sda_d   = 1'b1;
        tick_d  = '0;
        str_d   = '0;
      end
    endcase
  end

  // State and the registered result item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bc_q        <= '0;
      sr_q        <= '0;
      tick_q      <= '0;
      str_q       <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      st_q        <= ST_OK;
      rd_q        <= 1'b0;
      nack_q      <= 1'b0;
      rx_q        <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q <= phase_d;
        bc_q    <= bc_d;
        sr_q    <= sr_d;
        tick_q  <= tick_d;
        str_q   <= str_d;
        ack_q   <= ack_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        st_q    <= st_d;
        rd_q    <= rd_d;
        nack_q  <= nack_d;
        rx_q    <= rx_d;
        done_q  <= done_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result item is the state left by the tick.
  assign out_valid_o   = out_valid_q;
  assign scl_release_o = scl_q;
  assign sda_release_o = sda_q;
  assign busy_res_o    = (phase_q != PH_IDLE);
  assign done_res_o    = done_q;
  assign read_data_o   = rx_q;
  assign status_o      = st_q;

  // A completed command always leaves the engine idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> phase_q == PH_IDLE)
    else $error("done raised while still busy");

  // A result that waits to be taken freezes the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q && !out_ready_i |=> $stable(phase_q) && $stable(tick_q))
    else $error("sequencer moved under a stalled result");

  // The bit counter never runs past the acknowledge bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bc_q <= DataBits)
    else $error("bit counter overran");

  // A timeout reports with both lines released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_q && st_q == ST_TIMEOUT |-> scl_q && sda_q)
    else $error("timeout left a line pulled low");

endmodule

`default_nettype wire

@@ tb/i2c_master_byte_engine_unit_tb.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Feeds timebase ticks through the valid/ready input channel, with SCL and SDA
// taken from a small bus model that follows the engine's own line drives. A
// scoreboard steps its own model of the sequencer for every accepted item and
// compares every result item field by field. The run starts with directed
// commands, covering acknowledge, no-acknowledge and stretch timeouts at short
// and zero register settings and the largest stretch timeout, and then runs
// random transactions under several timings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit_tb;
  import i2cm_pkg::*;

  // Action codes beyond the defined set are ignored by the engine.
  localparam logic [ActionWidth-1:0] ActSpareFirst = 3'd5;
  localparam logic [ActionWidth-1:0] ActSpareLast  = 3'd7;
  localparam logic [CfgWidth-1:0]    CfgMax        = 16'hFFFF;
  localparam int unsigned            CntSat        = 65535;
  localparam int unsigned            IdleLimit     = 2000;
  localparam int unsigned            DrainCycles   = 10;
  localparam int                     ShortTmo      = 4;
  localparam int                     RandBudget    = 40;

  // Sequencer phases as the scoreboard tracks them.
  typedef enum logic [4:0] {
    S_IDLE, S_START_WAIT, S_START_HIGH, S_START_SDA, S_START_SCL,
    S_STOP_WAIT, S_STOP_HIGH, S_STOP_SDA, S_BIT_LOW, S_BIT_WAIT, S_BIT_HIGH, S_TAIL
  } seq_phase_e;

  // One result item, in port order.
  typedef struct packed {
    logic                 scl;
    logic                 sda;
    logic                 busy;
    logic                 done;
    logic [ByteWidth-1:0] rdata;
    status_e              st;
  } line_res_t;

  // Scoreboard: tracks the sequencer and holds the results still owed.
  class i2c_tick_scoreboard;
    logic [CfgWidth-1:0]    cfg_half;
    logic [CfgWidth-1:0]    cfg_stretch;
    seq_phase_e             phase;
    logic [BitCntWidth-1:0] bit_cnt;
    logic [ByteWidth-1:0]   shift;
    int unsigned            ticks;
    int unsigned            stretch;
    logic                   send_ack;
    logic                   scl_drv;
    logic                   sda_drv;
    status_e                last_st;
    logic                   rd_mode;
    logic                   nack_seen;
    logic [ByteWidth-1:0]   rx_byte;
    line_res_t              line_expect_q[$];
    int                     errors;
    int                     cmd_cnt[8];
    int                     n_done;
    int                     n_nack;
    int                     n_timeout;

    function new();
      cfg_half    = HalfPeriodReset;
      cfg_stretch = StretchReset;
      phase       = S_IDLE;
      bit_cnt     = '0;
      shift       = '0;
      ticks       = 0;
      stretch     = 0;
      send_ack    = 1'b0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
      last_st     = ST_OK;
      rd_mode     = 1'b0;
      nack_seen   = 1'b0;
      rx_byte     = '0;
      errors      = 0;
      n_done      = 0;
      n_nack      = 0;
      n_timeout   = 0;
      foreach (cmd_cnt[k]) cmd_cnt[k] = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgWidth-1:0] val);
      if (idx == REG_HALF_PERIOD) begin
        cfg_half = val;
      end else begin
        cfg_stretch = val;
      end
    endfunction

    function void move_to(seq_phase_e p, logic scl, logic sda);
      phase   = p;
      scl_drv = scl;
      sda_drv = sda;
      ticks   = 0;
      stretch = 0;
    endfunction

    // SDA level for the bit about to be driven: data, released, or the ACK slot.
    function logic next_level();
      if (bit_cnt < DataBits) begin
        return rd_mode ? 1'b1 : shift[ByteWidth-1];
      end
      return rd_mode ? ~send_ack : 1'b1;
    endfunction

    // A zero half period counts as one tick; the counter saturates.
    function bit half_elapsed();
      int unsigned lim;
      lim = (cfg_half == '0) ? 1 : cfg_half;
      if (ticks < CntSat) ticks++;
      return ticks >= lim;
    endfunction

    // 1 when SCL reads high, 0 while stretched, -1 once the wait has timed out.
    function int scl_wait(logic scl);
      if (scl) return 1;
      if (stretch < CntSat) stretch++;
      return (stretch >= cfg_stretch) ? -1 : 0;
    endfunction

    // Steps the sequencer by one accepted item and queues the result it owes.
    function void note_tick(logic [ActionWidth-1:0] act, logic [ByteWidth-1:0] data,
                            logic ack, logic scl, logic sda);
      logic      done;
      int        w;
      line_res_t r;
      done = 1'b0;
      case (phase)
        S_IDLE: begin
          if (act == ACT_START || act == ACT_STOP || act == ACT_WRITE || act == ACT_READ)
            cmd_cnt[act]++;
          if (act == ACT_START) begin
            move_to(S_START_WAIT, 1'b1, 1'b1);
          end else if (act == ACT_STOP) begin
            move_to(S_STOP_WAIT, 1'b1, 1'b0);
          end else if (act == ACT_WRITE || act == ACT_READ) begin
            rd_mode   = (act == ACT_READ);
            send_ack  = ack;
            shift     = rd_mode ? '0 : data;
            bit_cnt   = '0;
            nack_seen = 1'b0;
            move_to(S_BIT_LOW, 1'b0, next_level());
          end
        end
        S_START_WAIT, S_STOP_WAIT, S_BIT_WAIT: begin
          w = scl_wait(scl);
          if (w > 0) begin
            if (phase == S_START_WAIT) begin
              move_to(S_START_HIGH, 1'b1, 1'b1);
            end else if (phase == S_STOP_WAIT) begin
              move_to(S_STOP_HIGH, 1'b1, 1'b0);
            end else begin
              move_to(S_BIT_HIGH, 1'b1, sda_drv);
            end
          end else if (w < 0) begin
            // A read cut short during its data bits loses its byte.
            if (phase == S_BIT_WAIT && rd_mode && bit_cnt < DataBits) rx_byte = '0;
            move_to(S_IDLE, 1'b1, 1'b1);
            last_st = ST_TIMEOUT;
            done    = 1'b1;
            n_timeout++;
          end
        end
        S_START_HIGH: if (half_elapsed()) move_to(S_START_SDA, 1'b1, 1'b0);
        S_START_SDA:  if (half_elapsed()) move_to(S_START_SCL, 1'b0, 1'b0);
        S_START_SCL: begin
          if (half_elapsed()) begin
            move_to(S_IDLE, 1'b0, 1'b0);
            last_st = ST_OK;
            done    = 1'b1;
          end
        end
        S_STOP_HIGH: if (half_elapsed()) move_to(S_STOP_SDA, 1'b1, 1'b1);
        S_STOP_SDA: begin
          if (half_elapsed()) begin
            move_to(S_IDLE, 1'b1, 1'b1);
            last_st = ST_OK;
            done    = 1'b1;
          end
        end
        S_BIT_LOW: if (half_elapsed()) move_to(S_BIT_WAIT, 1'b1, sda_drv);
        S_BIT_HIGH: begin
          // SDA is sampled on the last tick of the high half.
          if (half_elapsed()) begin
            if (bit_cnt < DataBits) begin
              shift = {shift[ByteWidth-2:0], sda};
              if (bit_cnt == LastDataBit && rd_mode) rx_byte = shift;
              bit_cnt++;
              move_to(S_BIT_LOW, 1'b0, next_level());
            end else begin
              nack_seen = rd_mode ? 1'b0 : sda;
              move_to(S_TAIL, 1'b0, sda_drv);
            end
          end
        end
        S_TAIL: begin
          if (half_elapsed()) begin
            move_to(S_IDLE, 1'b0, 1'b1);
            last_st = nack_seen ? ST_NACK : ST_OK;
            if (nack_seen) n_nack++;
            done = 1'b1;
          end
        end
        default: move_to(S_IDLE, 1'b1, 1'b1);
      endcase
      if (done) n_done++;
      r.scl   = scl_drv;
      r.sda   = sda_drv;
      r.busy  = (phase != S_IDLE);
      r.done  = done;
      r.rdata = rx_byte;
      r.st    = last_st;
      line_expect_q.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(line_res_t got);
      line_res_t exp_r;
      if (line_expect_q.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
        return;
      end
      exp_r = line_expect_q.pop_front();
      cmp_field("scl_release", exp_r.scl, got.scl);
      cmp_field("sda_release", exp_r.sda, got.sda);
      cmp_field("busy_res", exp_r.busy, got.busy);
      cmp_field("done_res", exp_r.done, got.done);
      cmp_field("read_data", exp_r.rdata, got.rdata);
      cmp_field("status", exp_r.st, got.st);
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we      = 1'b0;
  cfg_reg_e               cfg_idx     = REG_HALF_PERIOD;
  logic [CfgWidth-1:0]    cfg_wdata   = '0;
  logic                   in_valid    = 1'b0;
  logic [ActionWidth-1:0] action      = ACT_NONE;
  logic [ByteWidth-1:0]   cmd_byte    = '0;
  logic                   ack_after   = 1'b0;
  logic                   scl_in      = 1'b1;
  logic                   sda_in      = 1'b1;
  logic                   out_ready   = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   scl_release;
  logic                   sda_release;
  logic                   busy_res;
  logic                   done_res;
  logic [ByteWidth-1:0]   read_data;
  logic [StatusWidth-1:0] status;

  i2c_tick_scoreboard sb = new();

  // Sender and bus model state.
  int unsigned burst_left  = 0;
  bit          fast_mode   = 1'b0;
  int          counted     = 0;
  int          stretch_left = 0;
  bit          wait_armed  = 1'b0;
  int          wait_no     = 0;
  int          forced_wait = -1;
  int          forced_len  = 0;
  int          forced_nack = -1;
  int          n_settings  = 1;
  int unsigned idle_cycles = 0;

  i2c_master_byte_engine_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .cmd_byte_i      (cmd_byte),
    .ack_after_read_i(ack_after),
    .scl_in_i        (scl_in),
    .sda_in_i        (sda_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .scl_release_o   (scl_release),
    .sda_release_o   (sda_release),
    .busy_res_o      (busy_res),
    .done_res_o      (done_res),
    .read_data_o     (read_data),
    .status_o        (status)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: switches between always ready, random stalls and a rotating mask.
  int unsigned rx_mode_left = 0;
  int unsigned rx_mode      = 0;
  logic [7:0]  rx_mask      = 8'hFF;
  always @(posedge clk_i) begin
    if (fast_mode) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 96);
        rx_mask      = 8'($urandom) | 8'h01;
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= rx_mask[0];
          rx_mask = {rx_mask[0], rx_mask[7:1]};
        end
      endcase
    end
  end

  // Result checking on every accepted result item.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_result(line_res_t'({scl_release, sda_release, busy_res, done_res,
                                   read_data, status}));
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Sends one tick. During a wait SCL reads high unless a stretch is in
  // progress, and it is random elsewhere; each wait picks a stretch length once, on entry.
  task automatic drive_tick(input logic [ActionWidth-1:0] act,
                            input logic [ByteWidth-1:0] data, input logic ack_b);
    logic        scl_b;
    logic        sda_b;
    logic        was_busy;
    int unsigned pick;
    if (sb.phase == S_START_WAIT || sb.phase == S_STOP_WAIT || sb.phase == S_BIT_WAIT) begin
      if (!wait_armed) begin
        wait_armed = 1'b1;
        pick = $urandom_range(0, 99);
        if (wait_no == forced_wait) begin
          stretch_left = forced_len;
        end else if (pick < 75) begin
          stretch_left = 0;
        end else if (pick < 99) begin
          stretch_left = $urandom_range(1, 6);
        end else begin
          stretch_left = int'(sb.cfg_stretch) + int'($urandom_range(0, 2));
        end
        wait_no++;
      end
      scl_b = (stretch_left == 0);
      if (stretch_left > 0) stretch_left--;
    end else begin
      wait_armed   = 1'b0;
      stretch_left = 0;
      scl_b        = 1'($urandom_range(0, 1));
    end
    // SDA mostly reads low where the engine pulls it; the slave answers the ACK slot.
    if (!sb.sda_drv) begin
      sda_b = ($urandom_range(0, 15) == 0);
    end else if (sb.phase == S_BIT_HIGH && sb.bit_cnt == DataBits && !sb.rd_mode) begin
      sda_b = (forced_nack >= 0) ? forced_nack[0] : ($urandom_range(0, 4) == 0);
    end else begin
      sda_b = 1'($urandom_range(0, 1));
    end
    if (!fast_mode && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    action    <= act;
    cmd_byte  <= data;
    ack_after <= ack_b;
    scl_in    <= scl_b;
    sda_in    <= sda_b;
    do @(posedge clk_i); while (!in_ready);
    was_busy = (sb.phase != S_IDLE);
    sb.note_tick(act, data, ack_b, scl_b, sda_b);
    if (was_busy || (act >= ACT_START && act <= ACT_READ)) counted++;
  endtask

  // Issues one command and keeps ticking until it completes. A stretch of
  // wlen ticks can be forced on wait number wait_idx, and the ACK answer too.
  task automatic run_cmd(input logic [ActionWidth-1:0] act, input logic [ByteWidth-1:0] data,
                         input logic ack_b, input int wait_idx, input int wlen,
                         input int nack);
    forced_wait = wait_idx;
    forced_len  = wlen;
    forced_nack = nack;
    wait_no     = 0;
    drive_tick(act, data, ack_b);
    // Commands arriving while busy must be ignored, so random codes go in.
    while (sb.phase != S_IDLE) begin
      drive_tick(ActionWidth'($urandom_range(0, 7)), ByteWidth'($urandom),
                 1'($urandom_range(0, 1)));
    end
    forced_wait = -1;
    forced_nack = -1;
  endtask

  // Register write once everything owed has come back.
  task automatic set_reg(input cfg_reg_e idx, input logic [CfgWidth-1:0] val);
    in_valid <= 1'b0;
    while (sb.line_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input logic [CfgWidth-1:0] half, input logic [CfgWidth-1:0] tmo);
    set_reg(REG_HALF_PERIOD, half);
    set_reg(REG_STRETCH, tmo);
    n_settings++;
  endtask

  // Random transactions: mostly start, address write, data bytes and stop,
  // with lone commands and ignored idle codes mixed in.
  task automatic run_random(input int budget);
    int                     goal;
    int unsigned            n;
    logic [ActionWidth-1:0] plan[$];
    goal = counted + budget;
    while (counted < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, 3);
        drive_tick((n == 0) ? ACT_NONE : ActionWidth'(ActSpareFirst + n - 1),
                   ByteWidth'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        if (plan.size() == 0) begin
          if ($urandom_range(0, 6) == 0) begin
            plan.push_back(ActionWidth'($urandom_range(ACT_START, ACT_READ)));
          end else begin
            plan.push_back(ACT_START);
            plan.push_back(ACT_WRITE);
            n = $urandom_range(0, 3);
            repeat (n) plan.push_back($urandom_range(0, 1) ? ACT_WRITE : ACT_READ);
            if ($urandom_range(0, 3) == 0) begin
              plan.push_back(ACT_START);
              plan.push_back(ACT_WRITE);
              plan.push_back(ACT_READ);
            end
            plan.push_back(ACT_STOP);
          end
        end
        run_cmd(plan.pop_front(), ByteWidth'($urandom), 1'($urandom_range(0, 1)), -1, 0, -1);
      end
    end
  endtask

  logic [CfgWidth-1:0] rnd_half[4] = '{16'd1, 16'd2, 16'd1, 16'd2};
  logic [CfgWidth-1:0] rnd_tmo[4]  = '{16'd3, 16'd1, 16'd8, 16'd0};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unused action codes and no command while idle change nothing.
    drive_tick(ACT_NONE, 8'h00, 1'b0);
    for (int k = int'(ActSpareFirst); k <= int'(ActSpareLast); k++) begin
      drive_tick(ActionWidth'(k), 8'hFF, 1'b1);
    end

    // Start and stop at the reset timing.
    run_cmd(ACT_START, 8'h00, 1'b0, -1, 0, -1);
    run_cmd(ACT_STOP, 8'h00, 1'b0, -1, 0, -1);

    // Short halves: both data extremes, ACK and NACK.
    set_timing(16'd1, CfgWidth'(ShortTmo));
    run_cmd(ACT_WRITE, 8'h00, 1'b0, -1, 0, 0);
    run_cmd(ACT_WRITE, 8'hFF, 1'b1, -1, 0, 1);
    run_cmd(ACT_READ, 8'h5A, 1'b1, -1, 0, -1);
    run_cmd(ACT_READ, 8'hA5, 1'b0, -1, 0, -1);

    // Stretch just short of the timeout, then exactly at it.
    run_cmd(ACT_START, 8'h00, 1'b0, 0, ShortTmo - 1, -1);
    run_cmd(ACT_START, 8'h00, 1'b0, 0, ShortTmo, -1);
    run_cmd(ACT_STOP, 8'h00, 1'b0, 0, ShortTmo, -1);
    run_cmd(ACT_WRITE, 8'hC3, 1'b0, 3, ShortTmo, -1);
    // Timeout inside a read clears the byte; on the ACK bit it keeps it.
    run_cmd(ACT_READ, 8'h00, 1'b1, -1, 0, -1);
    run_cmd(ACT_READ, 8'h00, 1'b1, 0, ShortTmo, -1);
    run_cmd(ACT_READ, 8'h00, 1'b1, -1, 0, -1);
    run_cmd(ACT_READ, 8'h00, 1'b0, int'(DataBits), ShortTmo, -1);

    // Zero registers: one-tick halves, and any stretched tick times out.
    set_timing('0, '0);
    run_cmd(ACT_START, 8'h00, 1'b0, 0, 0, -1);
    run_cmd(ACT_WRITE, 8'h96, 1'b0, 2, 1, -1);

    // Largest stretch timeout, run without idling.
    fast_mode = 1'b1;
    set_timing(16'd1, CfgMax);
    run_cmd(ACT_WRITE, 8'h3C, 1'b0, 0, 6, -1);
    fast_mode = 1'b0;

    foreach (rnd_half[k]) begin
      set_timing(rnd_half[k], rnd_tmo[k]);
      run_random(RandBudget);
    end

    in_valid <= 1'b0;
    while (sb.line_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d ticks under %0d timings: %0d starts, %0d stops, %0d writes, %0d reads.",
             counted, n_settings, sb.cmd_cnt[ACT_START], sb.cmd_cnt[ACT_STOP],
             sb.cmd_cnt[ACT_WRITE], sb.cmd_cnt[ACT_READ]);
    $display("%0d commands completed, %0d without acknowledge, %0d by stretch timeout.",
             sb.n_done, sb.n_nack, sb.n_timeout);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
